// ----- hdl/sle_pkg.sv -----
// Shared types and constants for the sorted list engine.
package sle_pkg;

  localparam int VALUE_W     = 32;
  localparam int CMD_W       = 3;
  localparam int POS_W       = 7;
  localparam int COUNT_W     = 7;
  localparam int DEF_CAPACITY = 64;

  localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP_MIN = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_MAX = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT
  } cell_op_e;

  typedef struct packed {
    cell_op_e                   op;
    logic signed [VALUE_W-1:0]  new_value;
  } cell_ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0]           command;
    logic signed [VALUE_W-1:0]  new_value;
    logic [POS_W-1:0]           position;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  out_value;
    logic                       ok;
    logic [COUNT_W-1:0]         held_count;
  } out_item_t;

endpackage

// ----- hdl/sorted_list_engine_top.sv -----
// Top level of the sorted list engine: command decode, count and result register.
// A result is in the output register in the cycle after its input transfer.
// Throughput: one command per cycle unless a held result stalls input; every cell
// updates in one step from its neighbors; the shared read bus selects one cell.
// Reset clears the count and the output valid; cell contents stay undefined
// until written and are never read beyond the count.
module sorted_list_engine_top import sle_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SEL_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [SEL_W-1:0] CAP = SEL_W'(CAPACITY);

  logic [SEL_W-1:0] count_q, count_d;
  logic             out_valid_q;
  out_item_t        out_q, out_d;
  logic             in_fire;

  cell_ctrl_t       ctrl;
  logic [SEL_W-1:0] sel;
  logic [SEL_W-1:0] pos_ext;

  logic                      after_w [CAPACITY];
  logic signed [VALUE_W-1:0] val_w   [CAPACITY];
  logic [VALUE_W-1:0]        rd_w    [CAPACITY];
  logic [VALUE_W-1:0]        rd_bus;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pos_ext     = SEL_W'(in_data_i.position);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                      left_after;
    logic signed [VALUE_W-1:0] left_value;
    logic signed [VALUE_W-1:0] right_value;
    if (i == 0) begin : g_first
      assign left_after = 1'b0;
      assign left_value = '0;
    end else begin : g_mid
      assign left_after = after_w[i-1];
      assign left_value = val_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_value = val_w[i];
    end else begin : g_inner
      assign right_value = val_w[i+1];
    end
    sle_cell #(
      .INDEX (i),
      .SEL_W (SEL_W)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .count_i       (count_q),
      .sel_i         (sel),
      .left_after_i  (left_after),
      .left_value_i  (left_value),
      .right_value_i (right_value),
      .after_o       (after_w[i]),
      .value_o       (val_w[i]),
      .rd_o          (rd_w[i])
    );
  end

  always_comb begin
    rd_bus = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_bus = rd_bus | rd_w[k];
    end
  end

  always_comb begin
    ctrl.op        = OP_HOLD;
    ctrl.new_value = in_data_i.new_value;
    count_d        = count_q;
    out_d.out_value = '0;
    out_d.ok        = 1'b0;
    sel = (in_data_i.command == CMD_READ) ? pos_ext : (count_q - SEL_W'(1));
    unique case (in_data_i.command)
      CMD_INSERT: begin
        if (count_q < CAP) begin
          ctrl.op  = OP_INSERT;
          count_d  = count_q + SEL_W'(1);
          out_d.ok = 1'b1;
        end
      end
      CMD_POP_MIN: begin
        if (count_q != '0) begin
          ctrl.op         = OP_SHIFT;
          count_d         = count_q - SEL_W'(1);
          out_d.ok        = 1'b1;
          out_d.out_value = val_w[0];
        end
      end
      CMD_POP_MAX: begin
        if (count_q != '0) begin
          count_d         = count_q - SEL_W'(1);
          out_d.ok        = 1'b1;
          out_d.out_value = rd_bus;
        end
      end
      CMD_READ: begin
        if (pos_ext < count_q) begin
          out_d.ok        = 1'b1;
          out_d.out_value = rd_bus;
        end else begin
          out_d.out_value = '1;
        end
      end
      CMD_CLEAR: begin
        count_d  = '0;
        out_d.ok = 1'b1;
      end
      default: begin
        count_d = count_q;
      end
    endcase
    out_d.held_count = count_d[COUNT_W-1:0];
    if (!in_fire) begin
      ctrl.op = OP_HOLD;
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP)
    else $error("count above capacity");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.command == CMD_CLEAR |=> count_q == '0 && out_q.ok)
    else $error("clear did not empty the list");

  a_full_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.command == CMD_INSERT && count_q == CAP
    |=> !out_q.ok && count_q == CAP)
    else $error("insert into full list not rejected");

  a_bad_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.command == CMD_READ && !(pos_ext < count_q)
    |=> !out_q.ok && out_q.out_value == '1)
    else $error("out of range read not flagged");

endmodule

// ----- hdl/sle_cell.sv -----
// One slot of the sorted register chain.
module sle_cell import sle_pkg::*; #(
  parameter int INDEX = 0,
  parameter int SEL_W = 7
) (
  input  logic                      clk_i,
  input  cell_ctrl_t                ctrl_i,
  input  logic [SEL_W-1:0]          count_i,
  input  logic [SEL_W-1:0]          sel_i,
  input  logic                      left_after_i,
  input  logic signed [VALUE_W-1:0] left_value_i,
  input  logic signed [VALUE_W-1:0] right_value_i,
  output logic                      after_o,
  output logic signed [VALUE_W-1:0] value_o,
  output logic [VALUE_W-1:0]        rd_o
);

  localparam logic [SEL_W-1:0] IDX = SEL_W'(INDEX);

  logic signed [VALUE_W-1:0] value_q, value_d;
  logic                      valid_here;
  logic                      gt;

  assign valid_here = IDX < count_i;
  assign gt         = valid_here && (value_q > ctrl_i.new_value);
  assign after_o    = gt || !valid_here;
  assign value_o    = value_q;
  assign rd_o       = (sel_i == IDX) ? value_q : '0;

  always_comb begin
    value_d = value_q;
    unique case (ctrl_i.op)
      OP_INSERT: begin
        if (left_after_i) begin
          value_d = left_value_i;
        end else if (after_o) begin
          value_d = ctrl_i.new_value;
        end
      end
      OP_SHIFT: value_d = right_value_i;
      default:  value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule
